// ===== design/tq_pkg.sv =====
package tq_pkg;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INS,
    ST_HEAD,
    ST_FILT
  } state_e;

  // Operation codes
  localparam logic [1:0] OP_SCHED   = 2'd0;
  localparam logic [1:0] OP_UNSCHED = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_SCHED   = 3'd0;
  localparam logic [2:0] KIND_UNSCHED = 3'd1;
  localparam logic [2:0] KIND_DELIVER = 3'd2;
  localparam logic [2:0] KIND_NONE    = 3'd3;
  localparam logic [2:0] KIND_CLEAR   = 3'd4;

endpackage

// ===== design/tq_mem.sv =====
module tq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // One read port, registered data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/tq_cmp.sv =====
module tq_cmp #(
  parameter int WIDTH = 32
) (
  input  logic             swap_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  output logic             lt_o
);

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;

  // Shared time compare: x < y, or y < x when swapped
  always_comb begin
    a    = swap_i ? y_i : x_i;
    b    = swap_i ? x_i : y_i;
    lt_o = (a < b);
  end

endmodule

// ===== design/timed_event_queue_top.sv =====
// Channel   Handshake          Payload
// command   start_i / busy_o   operation_i, event_time_i, goal_id_i
// result    res_valid_o        kind_o, delivered_goal_o, removed_count_o,
//                              status_o, new_head_o, last_o
//
// A command is taken when start_i is high and busy_o is low; each result word
// shows for one cycle under res_valid_o, registered after it is decided.
// Clear, and a schedule to a full or empty table, answer straight from idle. Other
// schedules walk down from the tail and move each entry not earlier up one slot.
// Unschedule and tick pass one entry per cycle through read port and comparator.
// Reset empties the table at once; results cannot be stalled.
module timed_event_queue_top #(
  parameter int DEPTH     = 16,
  parameter int TIME_BITS = 32,
  parameter int GOAL_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 operation_i,
  input  logic [TIME_BITS-1:0]       event_time_i,
  input  logic [GOAL_BITS-1:0]       goal_id_i,
  output logic                       res_valid_o,
  output logic [2:0]                 kind_o,
  output logic [GOAL_BITS-1:0]       delivered_goal_o,
  output logic [$clog2(DEPTH+1)-1:0] removed_count_o,
  output logic                       status_o,
  output logic                       new_head_o,
  output logic                       last_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);
  localparam int EW = TIME_BITS + GOAL_BITS;

  tq_pkg::state_e state_q, state_d;

  logic [1:0]           op_q, op_d;
  logic [TIME_BITS-1:0] time_q, time_d;
  logic [GOAL_BITS-1:0] goal_q, goal_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AW-1:0]        ptr_q, ptr_d;
  logic [CW-1:0]        rd_q, rd_d;
  logic [CW-1:0]        wr_q, wr_d;
  logic [CW-1:0]        rem_q, rem_d;
  logic                 dv_q, dv_d;
  logic                 stop_q, stop_d;
  logic                 pend_q, pend_d;
  logic [GOAL_BITS-1:0] pend_goal_q, pend_goal_d;

  logic                 res_valid_q, res_valid_d;
  logic [2:0]           kind_q, kind_d;
  logic [GOAL_BITS-1:0] dgoal_q, dgoal_d;
  logic [CW-1:0]        rcount_q, rcount_d;
  logic                 status_q, status_d;
  logic                 head_q, head_d;
  logic                 last_q, last_d;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [EW-1:0]        mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        mem_rdata;
  logic [TIME_BITS-1:0] rd_time;
  logic [GOAL_BITS-1:0] rd_goal;
  logic                 cmp_swap;
  logic                 cmp_lt;
  logic                 drop;

  // Entry table
  tq_mem #(
    .DEPTH(DEPTH),
    .WIDTH(EW)
  ) u_tq_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign rd_time = mem_rdata[EW-1:GOAL_BITS];
  assign rd_goal = mem_rdata[GOAL_BITS-1:0];

  // Insert asks entry < new time; tick asks now < entry
  assign cmp_swap = (state_q == tq_pkg::ST_INS);

  tq_cmp #(
    .WIDTH(TIME_BITS)
  ) u_tq_cmp (
    .swap_i(cmp_swap),
    .x_i   (time_q),
    .y_i   (rd_time),
    .lt_o  (cmp_lt)
  );

  // State and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tq_pkg::ST_IDLE;
      cnt_q       <= '0;
      dv_q        <= 1'b0;
      stop_q      <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dv_q        <= dv_d;
      stop_q      <= stop_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    time_q      <= time_d;
    goal_q      <= goal_d;
    ptr_q       <= ptr_d;
    rd_q        <= rd_d;
    wr_q        <= wr_d;
    rem_q       <= rem_d;
    pend_goal_q <= pend_goal_d;
    kind_q      <= kind_d;
    dgoal_q     <= dgoal_d;
    rcount_q    <= rcount_d;
    status_q    <= status_d;
    head_q      <= head_d;
    last_q      <= last_d;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    time_d      = time_q;
    goal_d      = goal_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    rem_d       = rem_q;
    dv_d        = dv_q;
    stop_d      = stop_q;
    pend_d      = pend_q;
    pend_goal_d = pend_goal_q;

    res_valid_d = 1'b0;
    kind_d      = tq_pkg::KIND_SCHED;
    dgoal_d     = '0;
    rcount_d    = '0;
    status_d    = 1'b0;
    head_d      = 1'b0;
    last_d      = 1'b0;

    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_raddr   = '0;
    drop        = 1'b0;

    case (state_q)
      tq_pkg::ST_IDLE: begin
        if (start_i) begin
          op_d   = operation_i;
          time_d = event_time_i;
          goal_d = goal_id_i;
          case (operation_i)
            tq_pkg::OP_SCHED: begin
              if (cnt_q == CW'(DEPTH)) begin
                // table full: drop the word
                res_valid_d = 1'b1;
                status_d    = 1'b1;
                last_d      = 1'b1;
              end else if (cnt_q == '0) begin
                mem_we      = 1'b1;
                mem_wdata   = {event_time_i, goal_id_i};
                cnt_d       = cnt_q + 1'b1;
                res_valid_d = 1'b1;
                head_d      = 1'b1;
                last_d      = 1'b1;
              end else begin
                // walk down from the tail
                mem_raddr = AW'(cnt_q - 1'b1);
                ptr_d     = AW'(cnt_q - 1'b1);
                state_d   = tq_pkg::ST_INS;
              end
            end
            tq_pkg::OP_UNSCHED, tq_pkg::OP_TICK: begin
              rd_d    = '0;
              wr_d    = '0;
              rem_d   = '0;
              dv_d    = 1'b0;
              stop_d  = 1'b0;
              pend_d  = 1'b0;
              state_d = tq_pkg::ST_FILT;
            end
            tq_pkg::OP_CLEAR: begin
              cnt_d       = '0;
              res_valid_d = 1'b1;
              kind_d      = tq_pkg::KIND_CLEAR;
              last_d      = 1'b1;
            end
            default: begin
              state_d = tq_pkg::ST_IDLE;
            end
          endcase
        end
      end

      tq_pkg::ST_INS: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q + 1'b1;
        if (!cmp_lt) begin
          // entry not earlier: move it up one slot
          mem_wdata = mem_rdata;
          if (ptr_q == '0) begin
            state_d = tq_pkg::ST_HEAD;
          end else begin
            mem_raddr = ptr_q - 1'b1;
            ptr_d     = ptr_q - 1'b1;
          end
        end else begin
          mem_wdata   = {time_q, goal_q};
          cnt_d       = cnt_q + 1'b1;
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          state_d     = tq_pkg::ST_IDLE;
        end
      end

      tq_pkg::ST_HEAD: begin
        mem_we      = 1'b1;
        mem_waddr   = '0;
        mem_wdata   = {time_q, goal_q};
        cnt_d       = cnt_q + 1'b1;
        res_valid_d = 1'b1;
        head_d      = 1'b1;
        last_d      = 1'b1;
        state_d     = tq_pkg::ST_IDLE;
      end

      tq_pkg::ST_FILT: begin
        // issue the next read
        if (rd_q < cnt_q) begin
          mem_raddr = rd_q[AW-1:0];
          rd_d      = rd_q + 1'b1;
          dv_d      = 1'b1;
        end else begin
          dv_d = 1'b0;
        end

        if (dv_q) begin
          if (op_q == tq_pkg::OP_UNSCHED) begin
            drop = (rd_goal == goal_q);
          end else begin
            drop = !stop_q && !cmp_lt;
          end
          if (drop) begin
            if (op_q == tq_pkg::OP_UNSCHED) begin
              rem_d = rem_q + 1'b1;
            end else begin
              // hold one delivery back to know which is last
              if (pend_q) begin
                res_valid_d = 1'b1;
                kind_d      = tq_pkg::KIND_DELIVER;
                dgoal_d     = pend_goal_q;
              end
              pend_d      = 1'b1;
              pend_goal_d = rd_goal;
            end
          end else begin
            // keep: compact toward the head
            mem_we    = 1'b1;
            mem_waddr = wr_q[AW-1:0];
            mem_wdata = mem_rdata;
            wr_d      = wr_q + 1'b1;
            stop_d    = 1'b1;
          end
        end else if (!(rd_q < cnt_q)) begin
          // pass done
          cnt_d       = wr_q;
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          state_d     = tq_pkg::ST_IDLE;
          if (op_q == tq_pkg::OP_UNSCHED) begin
            kind_d   = tq_pkg::KIND_UNSCHED;
            rcount_d = rem_q;
          end else if (pend_q) begin
            kind_d  = tq_pkg::KIND_DELIVER;
            dgoal_d = pend_goal_q;
            pend_d  = 1'b0;
          end else begin
            kind_d = tq_pkg::KIND_NONE;
          end
        end
      end

      default: begin
        state_d = tq_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o           = (state_q != tq_pkg::ST_IDLE);
  assign res_valid_o      = res_valid_q;
  assign kind_o           = kind_q;
  assign delivered_goal_o = dgoal_q;
  assign removed_count_o  = rcount_q;
  assign status_o         = status_q;
  assign new_head_o       = head_q;
  assign last_o           = last_q;

endmodule

// ===== design/tq_checker.sv =====
module tq_checker #(
  parameter int DEPTH = 16
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start_i,
  input logic                       busy_o,
  input logic [1:0]                 operation_i,
  input logic                       res_valid_o,
  input logic [2:0]                 kind_o,
  input logic [$clog2(DEPTH+1)-1:0] removed_count_o,
  input logic                       status_o,
  input logic                       new_head_o,
  input logic                       last_o
);

  // Only a delivery word can be followed by more words of the same command
  a_single_word_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && kind_o != tq_pkg::KIND_DELIVER |-> last_o)
    else $error("non-delivery word without last");

  // Removed count belongs to unschedule acks only
  a_count_only_unsched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && kind_o != tq_pkg::KIND_UNSCHED |-> removed_count_o == '0)
    else $error("removed count on wrong word kind");

  // A dropped insert never claims the head
  a_full_no_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && status_o |-> kind_o == tq_pkg::KIND_SCHED && !new_head_o)
    else $error("full status on bad word");

  // Clear answers in the next cycle
  a_clear_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i == tq_pkg::OP_CLEAR
    |=> res_valid_o && kind_o == tq_pkg::KIND_CLEAR && last_o)
    else $error("clear not acked");

endmodule

bind timed_event_queue_top tq_checker #(
  .DEPTH(DEPTH)
) u_tq_checker (.*);
